// ===== hw/rtl/polyline_arc_length_sampler_macros.svh =====
// Assertion macros shared by the RTL of the polyline arc-length sampler.
`ifndef POLYLINE_ARC_LENGTH_SAMPLER_MACROS_SVH
`define POLYLINE_ARC_LENGTH_SAMPLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PALS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PALS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/pals_pkg.sv =====
package pals_pkg;

    localparam int MaxVertices = 256;
    localparam int VtxAddrW    = $clog2(MaxVertices);
    localparam int CountW      = VtxAddrW + 1;

    localparam logic       REQ_LOAD  = 1'b0;
    localparam logic       REQ_QUERY = 1'b1;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FEW  = 2'd1;
    localparam logic [1:0] STAT_ZERO = 2'd2;

    localparam logic [1:0] REG_CLOSED_PATH = 2'd0;

    typedef struct packed {
        logic               req_type;
        logic               first_vertex;
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic [16:0]        param_frac;
    } t_req;

    typedef struct packed {
        logic signed [31:0] loc_x;
        logic signed [31:0] loc_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic [1:0]         status;
    } t_res;

endpackage

// ===== hw/rtl/polyline_arc_length_sampler.sv =====
// Load: a first vertex is stored directly; any other runs a 34-step square root.
// Query: on a closed path the closing segment root comes first, then the segment walk.
// Unless the segment found is empty, a ratio division follows when the target lies
// inside the path, then the interpolation and the two direction divisions.
// One word at a time: busy stays high until the result strobe; results cannot be stalled.
// Synchronous active-low reset clears the path, the total and closed_path.
module polyline_arc_length_sampler (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  pals_pkg::t_req        i_req,
    output logic                  o_valid,
    output pals_pkg::t_res        o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [1:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import pals_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0,  S_SQX  = 5'd1,  S_SQY  = 5'd2,
                           S_SQS  = 5'd3,  S_SQRT = 5'd4,  S_SQE  = 5'd5,
                           S_TOT  = 5'd6,  S_MUL1 = 5'd7,  S_MUL2 = 5'd8,
                           S_MUL3 = 5'd9,  S_WRD  = 5'd10, S_WCMP = 5'd11,
                           S_RA   = 5'd12, S_RB   = 5'd13, S_RC   = 5'd14,
                           S_DIV  = 5'd15, S_LX   = 5'd16, S_LXA  = 5'd17,
                           S_LYA  = 5'd18;

    localparam logic [1:0] DT_RATIO = 2'd0, DT_DX = 2'd1, DT_DY = 2'd2;

    logic [4:0]          r_state;
    logic [CountW-1:0]   r_count;
    logic [41:0]         r_total;
    logic                r_closed;
    logic                r_valid;
    logic                r_is_query;

    logic [31:0]         r_first_x, r_first_y, r_last_x, r_last_y;
    logic [32:0]         r_ux, r_uy;
    logic                r_sx, r_sy;
    logic [65:0]         r_prod, r_acc;
    logic [67:0]         r_sq_op;
    logic [37:0]         r_rem;
    logic [33:0]         r_root;
    logic [5:0]          r_cnt;
    logic [33:0]         r_close;
    logic [42:0]         r_tot;
    logic [16:0]         r_p;
    logic [59:0]         r_target;
    logic [42:0]         r_cum;
    logic [CountW-1:0]   r_i, r_sel;
    logic [33:0]         r_len;
    logic                r_found;
    logic [31:0]         r_ax, r_ay;
    logic [16:0]         r_ratio;
    logic [34:0]         r_drem;
    logic [16:0]         r_dnum;
    logic [16:0]         r_q;
    logic [1:0]          r_dtag;
    t_res                r_res;

    logic [31:0]         r_vx_mem [MaxVertices];
    logic [31:0]         r_vy_mem [MaxVertices];
    logic [33:0]         r_seg_mem [MaxVertices];
    logic [31:0]         r_vx_rd, r_vy_rd;
    logic [33:0]         r_seg_rd;

    logic                w_acc, w_cfg_wr, w_vwe;
    logic [VtxAddrW-1:0] w_vwa, w_vra;
    logic [32:0]         w_ma, w_mb;
    logic [65:0]         w_mul;
    logic [32:0]         w_dx_new, w_dy_new, w_dx_cl, w_dy_cl, w_dx_b, w_dy_b;
    logic [37:0]         w_rem2, w_trial;
    logic [34:0]         w_drem2;
    logic [16:0]         w_qn;
    logic [CountW-1:0]   w_nseg, w_last_i, w_nb;
    logic [33:0]         w_li;
    logic [42:0]         w_sum;
    logic                w_hit;
    logic [42:0]         w_tot_sum;
    logic [59:0]         w_rnum;
    logic [46:0]         w_dnum_x, w_dnum_y;
    logic [33:0]         w_off;

    assign w_acc    = start && !busy;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_res    = r_res;
    assign pready   = 1'b1;
    assign prdata   = {31'd0, r_closed};

    assign w_dx_new = {i_req.vertex_x[31], i_req.vertex_x} - {r_last_x[31], r_last_x};
    assign w_dy_new = {i_req.vertex_y[31], i_req.vertex_y} - {r_last_y[31], r_last_y};
    assign w_dx_cl  = {r_first_x[31], r_first_x} - {r_last_x[31], r_last_x};
    assign w_dy_cl  = {r_first_y[31], r_first_y} - {r_last_y[31], r_last_y};
    assign w_dx_b   = {r_vx_rd[31], r_vx_rd} - {r_ax[31], r_ax};
    assign w_dy_b   = {r_vy_rd[31], r_vy_rd} - {r_ay[31], r_ay};

    assign w_vwe = w_acc && (i_req.req_type == REQ_LOAD)
                   && (i_req.first_vertex || r_count == '0 || r_count != CountW'(MaxVertices));
    assign w_vwa = (i_req.first_vertex || r_count == '0) ? '0 : r_count[VtxAddrW-1:0];
    assign w_nb  = (r_sel + 1'b1 < r_count) ? r_sel + 1'b1 : '0;
    assign w_vra = (r_state == S_RB) ? w_nb[VtxAddrW-1:0] : r_sel[VtxAddrW-1:0];

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_SQX: begin
                w_ma = r_ux;
                w_mb = r_ux;
            end
            S_SQY: begin
                w_ma = r_uy;
                w_mb = r_uy;
            end
            S_MUL1: begin
                w_ma = {16'd0, r_tot[16:0]};
                w_mb = {16'd0, r_p};
            end
            S_MUL2: begin
                w_ma = {7'd0, r_tot[42:17]};
                w_mb = {16'd0, r_p};
            end
            S_LX: begin
                w_ma = r_ux;
                w_mb = {16'd0, r_ratio};
            end
            S_LXA: begin
                w_ma = r_uy;
                w_mb = {16'd0, r_ratio};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end
    assign w_mul = w_ma * w_mb;

    assign w_rem2  = {r_rem[35:0], r_sq_op[67:66]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_drem2 = {r_drem[33:0], r_dnum[16]};
    assign w_qn    = {r_q[15:0], (w_drem2 >= {1'b0, r_len})};

    assign w_nseg    = r_closed ? r_count : r_count - 1'b1;
    assign w_last_i  = r_count - 1'b1;
    assign w_li      = (r_i < w_last_i) ? r_seg_rd : r_close;
    assign w_sum     = r_cum + {9'd0, w_li};
    assign w_hit     = (r_target <= {1'b0, w_sum, 16'd0});
    assign w_tot_sum = {1'b0, r_total} + {9'd0, r_root};
    assign w_rnum    = r_target - {1'b0, r_cum, 16'd0};
    assign w_dnum_x  = {r_ux, 14'd0} + {14'd0, r_len[33:1]};
    assign w_dnum_y  = {r_uy, 14'd0} + {14'd0, r_len[33:1]};
    assign w_off     = 34'((r_prod + 66'd32768) >> 16);

    always_ff @(posedge i_clk) begin
        if (w_vwe) begin
            r_vx_mem[w_vwa] <= i_req.vertex_x;
            r_vy_mem[w_vwa] <= i_req.vertex_y;
        end
        r_vx_rd <= r_vx_mem[w_vra];
        r_vy_rd <= r_vy_mem[w_vra];
        if (r_state == S_SQE && !r_is_query) begin
            r_seg_mem[w_last_i[VtxAddrW-1:0]] <= r_root;
        end
        r_seg_rd <= r_seg_mem[r_i[VtxAddrW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_closed <= 1'b0;
        end else if (w_cfg_wr && paddr == REG_CLOSED_PATH) begin
            r_closed <= pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_total    <= '0;
            r_valid    <= 1'b0;
            r_is_query <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc && i_req.req_type == REQ_LOAD) begin
                        r_is_query <= 1'b0;
                        if (i_req.first_vertex || r_count == '0) begin
                            r_count   <= CountW'(1);
                            r_total   <= '0;
                            r_first_x <= i_req.vertex_x;
                            r_first_y <= i_req.vertex_y;
                            r_last_x  <= i_req.vertex_x;
                            r_last_y  <= i_req.vertex_y;
                        end else if (r_count != CountW'(MaxVertices)) begin
                            r_ux     <= w_dx_new[32] ? -w_dx_new : w_dx_new;
                            r_uy     <= w_dy_new[32] ? -w_dy_new : w_dy_new;
                            r_last_x <= i_req.vertex_x;
                            r_last_y <= i_req.vertex_y;
                            r_state  <= S_SQX;
                        end
                    end else if (w_acc) begin
                        r_is_query <= 1'b1;
                        r_p <= (i_req.param_frac > 17'd65536) ? 17'd65536 : i_req.param_frac;
                        if (r_count < CountW'(2)) begin
                            r_res   <= '{loc_x: '0, loc_y: '0, dir_x: '0, dir_y: '0,
                                         status: STAT_FEW};
                            r_valid <= 1'b1;
                        end else if (r_closed) begin
                            r_ux    <= w_dx_cl[32] ? -w_dx_cl : w_dx_cl;
                            r_uy    <= w_dy_cl[32] ? -w_dy_cl : w_dy_cl;
                            r_state <= S_SQX;
                        end else begin
                            r_close <= '0;
                            r_state <= S_TOT;
                        end
                    end
                end
                S_SQX: begin
                    r_prod  <= w_mul;
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_acc   <= r_prod;
                    r_prod  <= w_mul;
                    r_state <= S_SQS;
                end
                S_SQS: begin
                    r_sq_op <= {2'b00, r_acc + r_prod};
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_cnt   <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (w_rem2 >= w_trial) begin
                        r_rem  <= w_rem2 - w_trial;
                        r_root <= {r_root[32:0], 1'b1};
                    end else begin
                        r_rem  <= w_rem2;
                        r_root <= {r_root[32:0], 1'b0};
                    end
                    r_sq_op <= {r_sq_op[65:0], 2'b00};
                    r_cnt   <= r_cnt + 1'b1;
                    if (r_cnt == 6'd33) begin
                        r_state <= S_SQE;
                    end
                end
                S_SQE: begin
                    if (r_is_query) begin
                        r_close <= r_root;
                        r_state <= S_TOT;
                    end else begin
                        r_total <= w_tot_sum[42] ? '1 : w_tot_sum[41:0];
                        r_count <= r_count + 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_TOT: begin
                    r_tot   <= {1'b0, r_total} + {9'd0, r_close};
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_prod  <= w_mul;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_acc   <= r_prod;
                    r_prod  <= w_mul;
                    r_state <= S_MUL3;
                end
                S_MUL3: begin
                    r_target <= {r_prod[42:0], 17'd0} + r_acc[59:0];
                    r_cum    <= '0;
                    r_i      <= '0;
                    r_state  <= S_WRD;
                end
                S_WRD: begin
                    r_state <= S_WCMP;
                end
                S_WCMP: begin
                    r_sel <= r_i;
                    r_len <= w_li;
                    if (w_hit) begin
                        r_found <= 1'b1;
                        r_state <= S_RA;
                    end else begin
                        r_cum <= w_sum;
                        if (r_i + 1'b1 == w_nseg) begin
                            r_found <= 1'b0;
                            r_state <= S_RA;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_WRD;
                        end
                    end
                end
                S_RA: begin
                    r_state <= S_RB;
                end
                S_RB: begin
                    r_ax    <= r_vx_rd;
                    r_ay    <= r_vy_rd;
                    r_state <= S_RC;
                end
                S_RC: begin
                    r_sx <= w_dx_b[32];
                    r_sy <= w_dy_b[32];
                    r_ux <= w_dx_b[32] ? -w_dx_b : w_dx_b;
                    r_uy <= w_dy_b[32] ? -w_dy_b : w_dy_b;
                    priority if (r_len == '0) begin
                        r_res.loc_x  <= r_ax;
                        r_res.loc_y  <= r_ay;
                        r_res.dir_x  <= '0;
                        r_res.dir_y  <= '0;
                        r_res.status <= STAT_ZERO;
                        r_valid      <= 1'b1;
                        r_state      <= S_IDLE;
                    end else if (r_found) begin
                        r_drem  <= {1'b0, w_rnum[50:17]};
                        r_dnum  <= w_rnum[16:0];
                        r_q     <= '0;
                        r_cnt   <= '0;
                        r_dtag  <= DT_RATIO;
                        r_state <= S_DIV;
                    end else begin
                        r_ratio <= 17'd65536;
                        r_state <= S_LX;
                    end
                end
                S_DIV: begin
                    if (r_cnt == 6'd16) begin
                        r_cnt <= '0;
                        unique case (r_dtag)
                            DT_RATIO: begin
                                r_ratio <= (w_qn > 17'd65536) ? 17'd65536 : w_qn;
                                r_state <= S_LX;
                            end
                            DT_DX: begin
                                r_res.dir_x <= r_sx ? -w_qn[15:0] : w_qn[15:0];
                                r_drem  <= {1'b0, 4'd0, w_dnum_y[46:17]};
                                r_dnum  <= w_dnum_y[16:0];
                                r_q     <= '0;
                                r_dtag  <= DT_DY;
                            end
                            DT_DY: begin
                                r_res.dir_y  <= r_sy ? -w_qn[15:0] : w_qn[15:0];
                                r_res.status <= STAT_OK;
                                r_valid      <= 1'b1;
                                r_state      <= S_IDLE;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end else begin
                        r_drem <= (w_drem2 >= {1'b0, r_len}) ? w_drem2 - {1'b0, r_len} : w_drem2;
                        r_dnum <= {r_dnum[15:0], 1'b0};
                        r_q    <= w_qn;
                        r_cnt  <= r_cnt + 1'b1;
                    end
                end
                S_LX: begin
                    r_prod  <= w_mul;
                    r_state <= S_LXA;
                end
                S_LXA: begin
                    r_res.loc_x <= r_sx ? r_ax - w_off[31:0] : r_ax + w_off[31:0];
                    r_prod      <= w_mul;
                    r_state     <= S_LYA;
                end
                S_LYA: begin
                    r_res.loc_y <= r_sy ? r_ay - w_off[31:0] : r_ay + w_off[31:0];
                    r_drem  <= {1'b0, 4'd0, w_dnum_x[46:17]};
                    r_dnum  <= w_dnum_x[16:0];
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_dtag  <= DT_DX;
                    r_state <= S_DIV;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`include "polyline_arc_length_sampler_macros.svh"

    `PALS_ASSERT_IMP(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CountW'(MaxVertices), "vertex count above capacity")
    `PALS_ASSERT_IMP(a_walk_range, i_clk, i_rst_n, r_state == S_WCMP, r_i < w_nseg, "walk index past last segment")
    `PALS_ASSERT_IMP(a_status_code, i_clk, i_rst_n, r_valid, r_res.status != 2'd3, "undefined status code")
    `PALS_ASSERT_NXT(a_busy_no_word, i_clk, i_rst_n, w_acc && i_req.req_type == REQ_LOAD, !r_valid, "load produced a result word")

endmodule

// ===== bench/polyline_arc_length_sampler_test.sv =====
module polyline_arc_length_sampler_test;
    import pals_pkg::*;

    localparam int  LIMIT_CYCLES = 4000000;
    localparam logic [41:0] TOTAL_SAT = '1;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_req        i_req = '0;
    logic        o_valid;
    t_res        o_res;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    polyline_arc_length_sampler i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .o_valid(o_valid), .o_res(o_res),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 i_clk = ~i_clk;

    logic signed [31:0] vtx_x [MaxVertices];
    logic signed [31:0] vtx_y [MaxVertices];
    logic [33:0]        seg_mem [MaxVertices];
    int                 vtx_count;
    logic [41:0]        path_total;
    logic               closed_cfg;

    t_res expected_points [$];
    int   errors;
    int   cycles;
    int   words_sent;
    int   points_checked;
    bit   no_idle;

    function automatic logic [33:0] chord_length(logic signed [31:0] ax, logic signed [31:0] ay,
                                                 logic signed [31:0] bx, logic signed [31:0] by);
        logic signed [32:0] dx, dy;
        logic [32:0] ux, uy;
        logic [67:0] n, sq;
        logic [33:0] r, c;
        dx = {bx[31], bx} - {ax[31], ax};
        dy = {by[31], by} - {ay[31], ay};
        ux = dx[32] ? -dx : dx;
        uy = dy[32] ? -dy : dy;
        n = 68'(ux) * 68'(ux) + 68'(uy) * 68'(uy);
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            c = r | (34'd1 << b);
            sq = 68'(c) * 68'(c);
            if (sq <= n) r = c;
        end
        return r;
    endfunction

    function automatic logic [31:0] interp(logic signed [31:0] a, logic signed [31:0] b,
                                           logic [63:0] ratio);
        logic signed [32:0] d;
        logic [63:0] mag, off;
        d = {b[31], b} - {a[31], a};
        mag = d[32] ? 64'(-d) : 64'(d);
        off = (mag * ratio + 64'd32768) >> 16;
        return d[32] ? a - off[31:0] : a + off[31:0];
    endfunction

    function automatic logic [15:0] direction(logic signed [31:0] a, logic signed [31:0] b,
                                              logic [63:0] len);
        logic signed [32:0] d;
        logic [63:0] mag, q;
        d = {b[31], b} - {a[31], a};
        mag = d[32] ? 64'(-d) : 64'(d);
        q = (mag * 64'd16384 + len / 2) / len;
        return d[32] ? -q[15:0] : q[15:0];
    endfunction

    task automatic apply_load(t_req rq);
        logic [42:0] sum;
        logic [33:0] l;
        if (rq.first_vertex) begin
            vtx_count = 0;
            path_total = '0;
        end
        if (vtx_count >= MaxVertices) return;
        vtx_x[vtx_count] = rq.vertex_x;
        vtx_y[vtx_count] = rq.vertex_y;
        if (vtx_count > 0) begin
            l = chord_length(vtx_x[vtx_count-1], vtx_y[vtx_count-1],
                             vtx_x[vtx_count], vtx_y[vtx_count]);
            seg_mem[vtx_count-1] = l;
            sum = 43'(path_total) + 43'(l);
            path_total = (sum > 43'(TOTAL_SAT)) ? TOTAL_SAT : sum[41:0];
        end
        vtx_count++;
    endtask

    function automatic t_res sample_point(t_req rq);
        t_res r;
        int n, nseg, sel, bi;
        logic [63:0] total, close_len, target, cum, len, ratio, p, li;
        bit found;
        r = '0;
        n = vtx_count;
        if (n < 2) begin
            r.status = STAT_FEW;
            return r;
        end
        nseg = n - 1;
        close_len = 0;
        if (closed_cfg) begin
            close_len = chord_length(vtx_x[n-1], vtx_y[n-1], vtx_x[0], vtx_y[0]);
            nseg = n;
        end
        total = 64'(path_total) + close_len;
        p = 64'(rq.param_frac);
        if (p > 64'd65536) p = 64'd65536;
        target = total * p;
        cum = 0;
        found = 0;
        sel = 0;
        len = 0;
        ratio = 64'd65536;
        for (int i = 0; i < nseg; i++) begin
            li = (i < n - 1) ? 64'(seg_mem[i]) : close_len;
            if (target <= (cum + li) * 64'd65536) begin
                sel = i;
                len = li;
                found = 1;
                break;
            end
            cum += li;
        end
        if (!found) begin
            sel = nseg - 1;
            len = (sel < n - 1) ? 64'(seg_mem[sel]) : close_len;
        end
        bi = (sel + 1 < n) ? sel + 1 : 0;
        if (len == 0) begin
            r.status = STAT_ZERO;
            r.loc_x = vtx_x[sel];
            r.loc_y = vtx_y[sel];
        end else begin
            if (found) begin
                ratio = (target - cum * 64'd65536) / len;
                if (ratio > 64'd65536) ratio = 64'd65536;
            end
            r.status = STAT_OK;
            r.loc_x = interp(vtx_x[sel], vtx_x[bi], ratio);
            r.loc_y = interp(vtx_y[sel], vtx_y[bi], ratio);
            r.dir_x = direction(vtx_x[sel], vtx_x[bi], len);
            r.dir_y = direction(vtx_y[sel], vtx_y[bi], len);
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s at cycle %0d: got %h, expected %h", field, cycles, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("polyline_arc_length_sampler test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_valid) begin
            if (expected_points.size() == 0) begin
                $display("unexpected result word at cycle %0d", cycles);
                errors++;
            end else begin
                want = expected_points.pop_front();
                points_checked++;
                if (o_res.loc_x !== want.loc_x) report_mismatch("loc_x", o_res.loc_x, want.loc_x);
                if (o_res.loc_y !== want.loc_y) report_mismatch("loc_y", o_res.loc_y, want.loc_y);
                if (o_res.dir_x !== want.dir_x) report_mismatch("dir_x", o_res.dir_x, want.dir_x);
                if (o_res.dir_y !== want.dir_y) report_mismatch("dir_y", o_res.dir_y, want.dir_y);
                if (o_res.status !== want.status)
                    report_mismatch("status", o_res.status, want.status);
            end
        end
    end

    task automatic send_word(t_req rq);
        if (!no_idle && $urandom_range(99) < 12)
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        i_req = rq;
        start = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (rq.req_type == REQ_LOAD) apply_load(rq);
        else expected_points = {expected_points, sample_point(rq)};
        words_sent++;
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic load_vertex(bit first, logic [31:0] x, logic [31:0] y);
        t_req rq;
        rq = '0;
        rq.req_type = REQ_LOAD;
        rq.first_vertex = first;
        rq.vertex_x = x;
        rq.vertex_y = y;
        rq.param_frac = 17'($urandom);
        send_word(rq);
    endtask

    task automatic query_at(logic [16:0] t);
        t_req rq;
        rq = '0;
        rq.req_type = REQ_QUERY;
        rq.first_vertex = 1'($urandom);
        rq.vertex_x = $urandom;
        rq.vertex_y = $urandom;
        rq.param_frac = t;
        send_word(rq);
    endtask

    task automatic set_closed(bit v);
        while (expected_points.size() != 0 || busy) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = REG_CLOSED_PATH;
        pwdata = 32'(v);
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        closed_cfg = v;
    endtask

    task automatic test_directed();
        query_at(17'd0);
        load_vertex(1'b0, 32'h0001_0000, 32'h0);
        query_at(17'd65536);
        load_vertex(1'b0, 32'h0004_0000, 32'h0004_0000);
        load_vertex(1'b0, 32'h0004_0000, 32'h0004_0000);
        load_vertex(1'b0, 32'h8000_0000, 32'h7fff_ffff);
        query_at(17'd0);
        query_at(17'd20000);
        query_at(17'd40000);
        query_at(17'd65536);
        query_at(17'h1ffff);
        set_closed(1'b1);
        query_at(17'd60000);
        query_at(17'd65536);
        load_vertex(1'b1, 32'h7fff_ffff, 32'h8000_0000);
        load_vertex(1'b0, 32'h8000_0000, 32'h7fff_ffff);
        query_at(17'd32768);
        query_at(17'd65535);
        set_closed(1'b0);
        query_at(17'd1);
    endtask

    task automatic test_full_path();
        load_vertex(1'b1, $urandom, $urandom);
        for (int i = 0; i < MaxVertices + 3; i++)
            load_vertex(1'b0, $urandom, $urandom);
        query_at(17'd65536);
        query_at(17'($urandom_range(65536)));
        set_closed(1'b1);
        query_at(17'd65536);
        query_at(17'($urandom_range(65536)));
    endtask

    task automatic test_random(int count);
        int done, len;
        logic [31:0] x, y, px, py;
        done = 0;
        while (done < count) begin
            if (done > count / 3 && done < count / 2) no_idle = 1;
            else no_idle = 0;
            if ($urandom_range(9) == 0) begin
                if ($urandom_range(1)) query_at(17'($urandom));
                else load_vertex(1'($urandom), $urandom, $urandom);
                done++;
                continue;
            end
            len = $urandom_range(1, 10);
            px = 0;
            py = 0;
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(3))
                    0: begin x = $urandom; y = $urandom; end
                    1: begin x = px; y = py; end
                    default: begin
                        x = 32'($signed($urandom_range(0, 2000000)) - 1000000);
                        y = 32'($signed($urandom_range(0, 2000000)) - 1000000);
                    end
                endcase
                load_vertex(i == 0, x, y);
                px = x;
                py = y;
                done++;
            end
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(3) == 0) query_at(17'($urandom));
                else query_at(17'($urandom_range(65536)));
                done++;
            end
        end
        no_idle = 0;
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        words_sent = 0;
        points_checked = 0;
        no_idle = 0;
        vtx_count = 0;
        path_total = '0;
        closed_cfg = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        set_closed(1'b0);
        test_directed();
        test_full_path();
        set_closed(1'b0);
        test_random(450);
        set_closed(1'b1);
        test_random(450);
        while (expected_points.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        $display("Sent %0d words and checked %0d sampled points,", words_sent, points_checked);
        $display("covering open and closed paths, a full vertex store and degenerate segments.");
        if (errors == 0) begin
            $display("polyline_arc_length_sampler test passed");
        end else begin
            $display("polyline_arc_length_sampler test failed");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/pals_pkg.sv
hw/rtl/polyline_arc_length_sampler.sv
bench/polyline_arc_length_sampler_test.sv
